// ----- design/ohash_pkg.sv -----
// Shared constants, codes and control types of the open addressing hash table.
`timescale 1ns / 1ps

package ohash_pkg;

	// Table geometry. The home slot is the low bits of the key, so the size is a power of two.
	localparam int TABLE_SIZE = 1024;
	localparam int SLOT_W     = $clog2(TABLE_SIZE);
	localparam int COUNT_W    = SLOT_W + 1;
	localparam int KEY_W      = 32;

	// Item commands.
	localparam logic CMD_LOOKUP = 1'b0;
	localparam logic CMD_INSERT = 1'b1;

	// Probe modes.
	localparam logic MODE_LINEAR    = 1'b0;
	localparam logic MODE_QUADRATIC = 1'b1;

	// Result status codes.
	typedef enum logic [1:0] {
		ST_PRESENT  = 2'd0,
		ST_INSERTED = 2'd1,
		ST_MISS     = 2'd2,
		ST_LIMIT    = 2'd3
	} status_t;

	// Controller states.
	typedef enum logic [1:0] {
		S_CLEAR,
		S_IDLE,
		S_CHECK
	} state_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic start;
		logic step;
		logic finish;
		logic clr_wr;
	} ohash_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic found;
		logic last;
		logic out_free;
		logic clr_last;
	} ohash_sts_t;

endpackage

// ----- design/ohash_ctrl.sv -----
// Controller state machine that sequences clearing, probing and result hand-off.
`timescale 1ns / 1ps

module ohash_ctrl (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_stall,
	input  ohash_pkg::ohash_sts_t sts,
	output ohash_pkg::ohash_cmd_t cmd
);

	ohash_pkg::state_t state_q, state_d;

	// State register; reset starts the clearing pass over the valid bits.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ohash_pkg::S_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state and commands.
	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_stall = 1'b1;
		unique case (state_q)
			ohash_pkg::S_CLEAR: begin
				cmd.clr_wr = 1'b1;
				if (sts.clr_last) begin
					state_d = ohash_pkg::S_IDLE;
				end
			end
			ohash_pkg::S_IDLE: begin
				in_stall = 1'b0;
				if (in_valid) begin
					cmd.start = 1'b1;
					state_d   = ohash_pkg::S_CHECK;
				end
			end
			ohash_pkg::S_CHECK: begin
				// The search ends on a match, an empty slot or the probe limit.
				if (sts.found || sts.last) begin
					if (sts.out_free) begin
						cmd.finish = 1'b1;
						state_d    = ohash_pkg::S_IDLE;
					end
				end else begin
					cmd.step = 1'b1;
				end
			end
			default: begin
				state_d = ohash_pkg::S_IDLE;
			end
		endcase
	end

endmodule

// ----- design/ohash_dp.sv -----
// Datapath: slot memory, probe sequence registers, mode register and result register.
`timescale 1ns / 1ps

module ohash_dp (
	input  logic                                     clk,
	input  logic                                     arst_n,
	input  ohash_pkg::ohash_cmd_t                    cmd,
	output ohash_pkg::ohash_sts_t                    sts,
	input  logic                                     cfg_we,
	input  logic                                     cfg_mode,
	input  logic                                     in_cmd,
	input  logic signed [ohash_pkg::KEY_W-1:0]       in_key,
	output logic                                     out_valid,
	input  logic                                     out_stall,
	output ohash_pkg::status_t                       out_status,
	output logic        [ohash_pkg::SLOT_W-1:0]      out_slot,
	output logic        [ohash_pkg::COUNT_W-1:0]     out_count
);

	localparam int SW = ohash_pkg::SLOT_W;
	localparam int CW = ohash_pkg::COUNT_W;
	localparam int KW = ohash_pkg::KEY_W;

	// Each entry holds the valid bit above the key.
	logic [KW:0] mem [ohash_pkg::TABLE_SIZE];

	logic          mode_q;
	logic [SW-1:0] clr_q;
	logic          cmd_q;
	logic [KW-1:0] key_q;
	logic [SW-1:0] slot_q;
	logic [SW-1:0] inc_q;
	logic [CW-1:0] step_q;
	logic [KW:0]   rd_q;
	logic          out_valid_q;
	ohash_pkg::status_t out_status_q;
	logic [SW-1:0] out_slot_q;
	logic [CW-1:0] out_count_q;

	logic          rd_en;
	logic [SW-1:0] rd_addr;
	logic          wr_en;
	logic [SW-1:0] wr_addr;
	logic [KW:0]   wr_data;
	logic [SW-1:0] slot_next;
	logic          slot_empty;
	logic          slot_match;

	// Probe address: the home slot on start, the previous slot plus the step increment after.
	assign slot_next = slot_q + inc_q;
	assign rd_en     = cmd.start || cmd.step;
	assign rd_addr   = cmd.start ? in_key[SW-1:0] : slot_next;

	// Clearing pass writes empty entries; an insert writes the key with its valid bit.
	assign wr_en   = cmd.clr_wr || (cmd.finish && slot_empty && (cmd_q == ohash_pkg::CMD_INSERT));
	assign wr_addr = cmd.clr_wr ? clr_q : slot_q;
	assign wr_data = cmd.clr_wr ? '0 : {1'b1, key_q};

	// Slot memory with a registered read port.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_q <= mem[rd_addr];
		end
	end

	// Decision on the slot just read.
	assign slot_empty = !rd_q[KW];
	assign slot_match = rd_q[KW] && (rd_q[KW-1:0] == key_q);

	assign sts.found    = slot_empty || slot_match;
	assign sts.last     = (step_q == CW'(ohash_pkg::TABLE_SIZE - 1));
	assign sts.out_free = !out_valid_q || !out_stall;
	assign sts.clr_last = (clr_q == SW'(ohash_pkg::TABLE_SIZE - 1));

	// Control registers: probe mode, clearing counter and result valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q      <= ohash_pkg::MODE_LINEAR;
			clr_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				mode_q <= cfg_mode;
			end
			if (cmd.clr_wr) begin
				clr_q <= clr_q + SW'(1);
			end
			if (cmd.finish) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Probe sequence. Quadratic offsets 2k*k advance by 4k+2, so the increment grows by four.
	always_ff @(posedge clk) begin
		if (cmd.start) begin
			cmd_q  <= in_cmd;
			key_q  <= in_key;
			slot_q <= in_key[SW-1:0];
			inc_q  <= (mode_q == ohash_pkg::MODE_QUADRATIC) ? SW'(2) : SW'(1);
			step_q <= '0;
		end else if (cmd.step) begin
			slot_q <= slot_next;
			inc_q  <= inc_q + ((mode_q == ohash_pkg::MODE_QUADRATIC) ? SW'(4) : SW'(0));
			step_q <= step_q + CW'(1);
		end
	end

	// Result register.
	always_ff @(posedge clk) begin
		if (cmd.finish) begin
			if (slot_empty) begin
				out_status_q <= (cmd_q == ohash_pkg::CMD_INSERT) ? ohash_pkg::ST_INSERTED
				                                                  : ohash_pkg::ST_MISS;
				out_slot_q   <= slot_q;
				out_count_q  <= step_q;
			end else if (slot_match) begin
				out_status_q <= ohash_pkg::ST_PRESENT;
				out_slot_q   <= slot_q;
				out_count_q  <= step_q;
			end else begin
				out_status_q <= ohash_pkg::ST_LIMIT;
				out_slot_q   <= '0;
				out_count_q  <= CW'(ohash_pkg::TABLE_SIZE);
			end
		end
	end

	assign out_valid  = out_valid_q;
	assign out_status = out_status_q;
	assign out_slot   = out_slot_q;
	assign out_count  = out_count_q;

	// A result is never loaded over one that is still waiting.
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.finish |-> !(out_valid_q && out_stall))
		else $error("result register overwritten while stalled");

	// The search never steps past the probe limit.
	a_step_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.step |-> (step_q < CW'(ohash_pkg::TABLE_SIZE - 1)))
		else $error("probe step beyond table size");

	// A finished search leaves a valid result on the next cycle.
	a_finish_valid: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.finish |=> out_valid_q)
		else $error("finished search gave no result");

endmodule

// ----- design/open_addressing_hash_table_top.sv -----
// Top level of the open addressing hash table: controller and datapath.
`timescale 1ns / 1ps

// Hash table of 1024 signed 32-bit keys with linear or quadratic probing. After reset
// the block runs a clearing pass over the slot memory and holds in_stall high meanwhile;
// configuration writes are taken at any time. An accepted item is probed slot by slot
// through the single read port of the slot memory, and in_stall stays high until its
// result is loaded. The result waits in an output register, so the next item is accepted
// while it is still stalled. Write probe_mode only while the block is idle, since a
// search reads the mode at every probe step.
module open_addressing_hash_table_top (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_valid,
	output logic                                 cfg_ready,
	input  logic                                 cfg_data,
	input  logic                                 in_valid,
	output logic                                 in_stall,
	input  logic                                 cmd,
	input  logic signed [ohash_pkg::KEY_W-1:0]   key,
	output logic                                 out_valid,
	input  logic                                 out_stall,
	output logic        [1:0]                    status,
	output logic        [ohash_pkg::SLOT_W-1:0]  slot_index,
	output logic        [ohash_pkg::COUNT_W-1:0] probe_count
);

	ohash_pkg::ohash_cmd_t ctl_cmd;
	ohash_pkg::ohash_sts_t dp_sts;
	ohash_pkg::status_t    status_e;

	// The mode register takes a write at any time.
	assign cfg_ready = 1'b1;
	assign status    = status_e;

	ohash_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.sts      (dp_sts),
		.cmd      (ctl_cmd)
	);

	ohash_dp u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (ctl_cmd),
		.sts        (dp_sts),
		.cfg_we     (cfg_valid && cfg_ready),
		.cfg_mode   (cfg_data),
		.in_cmd     (cmd),
		.in_key     (key),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.out_status (status_e),
		.out_slot   (slot_index),
		.out_count  (probe_count)
	);

endmodule
